FILE: rtl/drrip_cache_replacement_top_defines.svh
// Assertion macros shared by the DRRIP replacement checker.
// No dependencies; the including file supplies i_clk and i_rst_n.
`ifndef DRRIP_CACHE_REPLACEMENT_TOP_DEFINES_SVH
`define DRRIP_CACHE_REPLACEMENT_TOP_DEFINES_SVH

// Implication into the next cycle, ignored while reset is asserted.
`define DRRIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drrip: next-cycle check failed");

// Condition that must hold on every edge outside reset.
`define DRRIP_ASSERT_HOLD(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("drrip: invariant check failed");

// Implication into the next cycle, also checked across reset.
`define DRRIP_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("drrip: reset-time check failed");

`endif

FILE: rtl/drrip_pkg.sv
// Shared constants, types and set-class helper for the DRRIP replacement block.
// No dependencies.
`default_nettype none

package drrip_pkg;

    // Fixed field widths of the access and result beats
    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int DRAW_W    = 5;
    localparam int VICTIM_W  = 4;

    // Re-reference prediction values
    localparam int RRPV_W = 2;
    typedef logic [RRPV_W-1:0] t_rrpv;
    localparam t_rrpv RRPV_TOP    = 2'd3;
    localparam t_rrpv RRPV_LONG   = 2'd2;
    localparam t_rrpv RRPV_RARE   = 2'd1;
    localparam t_rrpv RRPV_NEAR   = 2'd0;

    // Leader set spacing and the rare bimodal draw
    localparam int SRRIP_PERIOD_W = 6;
    localparam int BRRIP_PERIOD   = 65;
    localparam int BRRIP_LEADERS  = (2**SET_IN_W - 1) / BRRIP_PERIOD + 1;
    localparam logic [DRAW_W-1:0] RARE_DRAW = 5'd31;

    // Operation codes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // BRRIP leader: set 1 or any multiple of 65 (compared against every multiple)
    function automatic logic is_brrip_leader(input logic [SET_IN_W-1:0] s);
        logic found;
        found = (s == SET_IN_W'(1));
        for (int k = 0; k < BRRIP_LEADERS; k++) begin
            found = found | (s == SET_IN_W'(k * BRRIP_PERIOD));
        end
        return found;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/drrip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module drrip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/drrip_cache_replacement_top.sv
// DRRIP replacement state: a query compares one way of its row per cycle, then
// writes the aged row back and returns a victim; an update rewrites the addressed
// way and returns. A set_index >= NUM_SETS is reduced by NUM_SETS until in range.
// One item at a time: next beat accepted the cycle after its result is registered.
// Synchronous active-low reset starts a clearing pass over all NUM_SETS rows that sets
// every value to 3; no beat is accepted until it ends. Selector resets to half.
`default_nettype none

module drrip_cache_replacement_top #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int SELECTOR_MAX = 1023
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // access channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_operation,
    input  wire [drrip_pkg::SET_IN_W-1:0]       i_set_index,
    input  wire [drrip_pkg::WAY_IN_W-1:0]       i_way_index,
    input  wire                                 i_was_hit,
    input  wire [drrip_pkg::DRAW_W-1:0]         i_random_draw,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [drrip_pkg::VICTIM_W-1:0]      o_victim_way,
    output logic                                o_use_bimodal
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int ROW_W = NUM_WAYS * drrip_pkg::RRPV_W;
    localparam int SEL_W = $clog2(SELECTOR_MAX + 1);
    localparam logic [SEL_W-1:0] SEL_MAX  = SEL_W'(SELECTOR_MAX);
    localparam logic [SEL_W-1:0] SEL_HALF = SEL_W'(SELECTOR_MAX / 2);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                          r_state, n_state;
    logic [SET_W-1:0]                    r_clr;
    logic                                r_op;
    logic [drrip_pkg::SET_IN_W-1:0]      r_set;
    logic [drrip_pkg::WAY_IN_W-1:0]      r_way_in;
    logic                                r_hit;
    logic [drrip_pkg::DRAW_W-1:0]        r_draw;
    logic [WAY_W-1:0]                    r_scan;
    drrip_pkg::t_rrpv                    r_max;
    logic [WAY_W-1:0]                    r_best;
    logic [SEL_W-1:0]                    r_sel, n_sel;
    logic                                r_out_valid;
    logic [drrip_pkg::VICTIM_W-1:0]      r_victim;
    logic                                r_bimodal;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_set_big;
    logic [SET_W-1:0]                    w_set_addr;
    logic [ROW_W-1:0]                    w_rd_row;
    drrip_pkg::t_rrpv                    w_field;
    drrip_pkg::t_rrpv                    w_age;
    logic [ROW_W-1:0]                    w_aged_row;
    logic [ROW_W-1:0]                    w_upd_row;
    drrip_pkg::t_rrpv                    w_fill;
    drrip_pkg::t_rrpv                    w_bim_fill;
    drrip_pkg::t_rrpv                    w_new_val;
    logic                                w_srrip_lead;
    logic                                w_brrip_lead;
    logic                                w_way_ok;
    logic                                w_ram_we;
    logic [SET_W-1:0]                    w_ram_waddr;
    logic [ROW_W-1:0]                    w_ram_wdata;
    logic                                w_ram_re;

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_set_big  = 32'(r_set) >= NUM_SETS;
    assign w_set_addr = SET_W'(r_set);

    // Row storage: one word of NUM_WAYS 2-bit values per set
    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_set_addr),
        .o_rd_data (w_rd_row)
    );

    // Shared compare unit: one way of the row per cycle
    assign w_field = w_rd_row[r_scan * drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W];

    // Aging lifts the largest value to 3; the first way at the max becomes the victim
    assign w_age = drrip_pkg::RRPV_TOP - r_max;
    always_comb begin
        for (int k = 0; k < NUM_WAYS; k++) begin
            w_aged_row[k * drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] =
                w_rd_row[k * drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] + w_age;
        end
    end

    // Set class and insertion value
    assign w_srrip_lead = (r_set[drrip_pkg::SRRIP_PERIOD_W-1:0] == '0);
    assign w_brrip_lead = drrip_pkg::is_brrip_leader(r_set);
    assign w_bim_fill   = (r_draw == drrip_pkg::RARE_DRAW) ? drrip_pkg::RRPV_RARE
                                                           : drrip_pkg::RRPV_LONG;
    always_comb begin
        if (w_srrip_lead) begin
            w_fill = drrip_pkg::RRPV_LONG;
        end else if (w_brrip_lead || (r_sel > SEL_HALF)) begin
            w_fill = w_bim_fill;
        end else begin
            w_fill = drrip_pkg::RRPV_LONG;
        end
    end
    assign w_new_val = r_hit ? drrip_pkg::RRPV_NEAR : w_fill;
    assign w_way_ok  = 32'(r_way_in) < NUM_WAYS;

    // Updated row: only the addressed way changes
    always_comb begin
        for (int k = 0; k < NUM_WAYS; k++) begin
            w_upd_row[k * drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] =
                (32'(r_way_in) == 32'(k)) ? w_new_val
                    : w_rd_row[k * drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W];
        end
    end

    // Selector: leaders move it on a fill, saturating at both ends
    always_comb begin
        n_sel = r_sel;
        if (r_state == ST_UPDATE && !r_hit) begin
            if (w_srrip_lead) begin
                if (r_sel < SEL_MAX) begin
                    n_sel = r_sel + SEL_W'(1);
                end
            end else if (w_brrip_lead) begin
                if (r_sel != '0) begin
                    n_sel = r_sel - SEL_W'(1);
                end
            end
        end
    end

    // RAM port control
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_set_addr;
        w_ram_wdata = w_upd_row;
        w_ram_re    = (r_state == ST_REDUCE) && !w_set_big;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '1;
            end
            ST_UPDATE: begin
                w_ram_we = w_way_ok;
            end
            ST_WRITE: begin
                w_ram_we    = (r_max != drrip_pkg::RRPV_TOP);
                w_ram_wdata = w_aged_row;
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == LAST_SET) n_state = ST_IDLE;
            ST_IDLE:   if (w_accept) n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (!w_set_big) begin
                    n_state = (r_op == drrip_pkg::OP_QUERY) ? ST_SCAN : ST_UPDATE;
                end
            end
            ST_SCAN:   if (r_scan == LAST_WAY) n_state = ST_WRITE;
            ST_UPDATE: n_state = ST_DONE;
            ST_WRITE:  n_state = ST_DONE;
            ST_DONE:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_sel       <= SEL_HALF;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Beat capture, set reduction and scan registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_operation;
            r_set    <= i_set_index;
            r_way_in <= i_way_index;
            r_hit    <= i_was_hit;
            r_draw   <= i_random_draw;
        end
        if (r_state == ST_REDUCE) begin
            if (w_set_big) begin
                r_set <= r_set - drrip_pkg::SET_IN_W'(NUM_SETS);
            end
            r_scan <= '0;
            r_max  <= drrip_pkg::RRPV_NEAR;
            r_best <= '0;
        end
        if (r_state == ST_SCAN) begin
            r_scan <= r_scan + WAY_W'(1);
            if (w_field > r_max) begin
                r_max  <= w_field;
                r_best <= r_scan;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_victim  <= (r_op == drrip_pkg::OP_QUERY) ? drrip_pkg::VICTIM_W'(r_best) : '0;
            r_bimodal <= (r_sel > SEL_HALF);
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_victim_way  = r_victim;
    assign o_use_bimodal = r_bimodal;

endmodule

`default_nettype wire

FILE: rtl/drrip_chk.sv
// Port-level checker for the DRRIP replacement top level, bound to it below.
// Depends on drrip_pkg and drrip_cache_replacement_top_defines.svh.
`default_nettype none
`include "drrip_cache_replacement_top_defines.svh"

module drrip_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_stall,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire [drrip_pkg::VICTIM_W-1:0]    o_victim_way,
    input wire                              o_use_bimodal
);

    logic [1:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_beat = o_valid && !i_stall;

    // Items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (w_in_beat && !w_out_beat) begin
            r_pend <= r_pend + 2'd1;
        end else if (!w_in_beat && w_out_beat) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // Clearing pass holds the access channel off right after reset
    `DRRIP_ASSERT_NEXT_RST(a_stall_after_reset, !i_rst_n, o_stall)
    // Only one item in the sequencer: the block stalls right after taking a beat
    `DRRIP_ASSERT_NEXT(a_busy_after_accept, w_in_beat, o_stall)
    // At most two undelivered items: one in the result register, one held back
    `DRRIP_ASSERT_HOLD(a_two_in_flight, r_pend <= 2'd2)
    // A stalled result beat keeps its payload
    `DRRIP_ASSERT_NEXT(a_result_held, o_valid && i_stall,
        o_valid && $stable(o_victim_way) && $stable(o_use_bimodal))

endmodule

bind drrip_cache_replacement_top drrip_chk u_drrip_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_victim_way  (o_victim_way),
    .o_use_bimodal (o_use_bimodal)
);

`default_nettype wire
